@@ src/bua_pkg.sv @@
// Package for the broadcast update acknowledgement tracker.
// Holds the opcodes, update kinds, register indexes and the table entry type.
// No dependencies.
`default_nettype none

package bua_pkg;

    // Default number of table entries.
    localparam int TABLE_DEPTH_DEF = 64;

    // Field widths.
    localparam int ID_W     = 16;
    localparam int SEQ_W    = 16;
    localparam int COUNT_W  = 7;
    localparam int KIND_W   = 2;
    localparam int OP_W     = 2;
    localparam int MAXREP_W = 8;
    localparam int REP_W    = 9;
    localparam int REG_IDX_W = 1;

    // Input opcodes.
    localparam logic [OP_W-1:0] OP_REPORT       = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK         = 2'd1;
    localparam logic [OP_W-1:0] OP_START_SENSOR = 2'd2;
    localparam logic [OP_W-1:0] OP_START_RP     = 2'd3;

    // Update kinds.
    localparam logic [KIND_W-1:0] KIND_NONE   = 2'h0;
    localparam logic [KIND_W-1:0] KIND_RP     = 2'h1;
    localparam logic [KIND_W-1:0] KIND_SENSOR = 2'h2;

    // Configuration register indexes.
    localparam logic [REG_IDX_W-1:0] REG_MAX_REPEATS = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_TEST_MODE   = 1'd1;

    // Register reset values.
    localparam logic [MAXREP_W-1:0] MAX_REPEATS_RST = 8'd3;

    // One table entry as held in the entry memory.
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [SEQ_W-1:0] seq;
    } entry_t;

endpackage

`default_nettype wire

@@ src/bua_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Used for the device table. No dependencies.
`default_nettype none

module bua_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ src/broadcast_update_ack_tracker.sv @@
// Top level of the broadcast update acknowledgement tracker.
// Depends on bua_pkg and on bua_ram for the device table.
//
// The block takes one item at a time from the input stream: device reports,
// send ticks and update starts (opcode in s_tuser). A report walks the held
// entries through the single read port of the device table. A tick with an
// active update kind and held entries (or test mode) makes a removal pass,
// which moves the last entry into each removed slot, and an acknowledgement
// pass over the same port, and then finishes; any other tick goes straight
// to the finish. Each tick produces one result on the output stream; the
// result waits in an output register, and the block goes on taking reports
// and starts meanwhile. The configuration port may be written at any time
// the block is idle.
`default_nettype none

module broadcast_update_ack_tracker
    import bua_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    // Configuration write port.
    input  wire logic                 cfg_we,
    input  wire logic [REG_IDX_W-1:0] cfg_addr,
    input  wire logic [MAXREP_W-1:0]  cfg_wdata,
    // Input stream.
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [31:0]          s_tdata,   // dev_id[15:0], dev_seq[31:16]
    input  wire logic [OP_W-1:0]      s_tuser,   // opcode[1:0]
    // Output stream.
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [23:0]          m_tdata,   // send_seq[15:0], device_count[22:16]
    output logic      [2:0]           m_tuser    // send_valid[0], send_kind[2:1]
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int EW    = $bits(entry_t);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RPT_RD,
        S_RPT_CMP,
        S_PR_RD,
        S_PR_CMP,
        S_PR_MOVE,
        S_CK_RD,
        S_CK_CMP,
        S_FIN
    } state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [KIND_W-1:0]    kind_reg, kind_next;
    logic [SEQ_W-1:0]     cur_reg, cur_next;
    logic [REP_W-1:0]     rep_reg, rep_next;
    logic [MAXREP_W-1:0]  maxrep_reg, maxrep_next;
    logic                 test_reg, test_next;
    logic                 run_reg, run_next;
    logic                 ack_reg, ack_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_sv_reg, out_sv_next;
    logic [KIND_W-1:0]    out_kind_reg, out_kind_next;
    logic [SEQ_W-1:0]     out_seq_reg, out_seq_next;
    logic [CNT_W-1:0]     out_cnt_reg, out_cnt_next;

    // Latched report payload.
    logic [ID_W-1:0]      id_reg;
    logic [SEQ_W-1:0]     seq_reg;

    // Table memory controls.
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    entry_t               ram_wdata;
    logic [AW-1:0]        ram_raddr;
    entry_t               rd_entry;
    logic [EW-1:0]        ram_rdata;

    // Finishing arithmetic for a running tick.
    logic                 adv;
    logic [SEQ_W-1:0]     cur1;
    logic [REP_W-1:0]     rep1;
    logic [REP_W-1:0]     rep2;

    logic                 in_xfer;
    logic                 out_free;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign rd_entry = entry_t'(ram_rdata);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, COUNT_W'(out_cnt_reg), out_seq_reg};
    assign m_tuser  = {out_kind_reg, out_sv_reg};

    bua_ram #(
        .WIDTH(EW),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(EW'(ram_wdata)),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    // Advance and repeat handling at the end of a running tick.
    always_comb
    begin
        adv  = ack_reg || test_reg;
        cur1 = adv ? (cur_reg + SEQ_W'(1)) : cur_reg;
        rep1 = adv ? '0 : rep_reg;
        rep2 = rep1 + REP_W'(1);
    end

    // Sequencer next state, table accesses and output register loading.
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        kind_next      = kind_reg;
        cur_next       = cur_reg;
        rep_next       = rep_reg;
        maxrep_next    = maxrep_reg;
        test_next      = test_reg;
        run_next       = run_reg;
        ack_next       = ack_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_sv_next    = out_sv_reg;
        out_kind_next  = out_kind_reg;
        out_seq_next   = out_seq_reg;
        out_cnt_next   = out_cnt_reg;
        ram_we         = 1'b0;
        ram_waddr      = idx_reg[AW-1:0];
        ram_wdata      = '{id: id_reg, seq: seq_reg};
        ram_raddr      = idx_reg[AW-1:0];

        // Configuration writes.
        if (cfg_we)
        begin
            case (cfg_addr)
                REG_MAX_REPEATS: maxrep_next = cfg_wdata;
                REG_TEST_MODE:   test_next   = cfg_wdata[0];
                default:         ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    idx_next = '0;
                    case (s_tuser)
                        OP_REPORT:
                        begin
                            if (cnt_reg < CNT_W'(TABLE_DEPTH))
                            begin
                                state_next = S_RPT_RD;
                            end
                        end
                        OP_TICK:
                        begin
                            if (kind_reg != KIND_NONE && (cnt_reg != '0 || test_reg))
                            begin
                                run_next   = 1'b1;
                                state_next = S_PR_RD;
                            end
                            else
                            begin
                                run_next   = 1'b0;
                                state_next = S_FIN;
                            end
                        end
                        OP_START_SENSOR:
                        begin
                            rep_next  = '0;
                            cur_next  = '0;
                            kind_next = KIND_SENSOR;
                        end
                        default:
                        begin
                            rep_next  = '0;
                            cur_next  = '0;
                            kind_next = KIND_RP;
                        end
                    endcase
                end
            end

            // Search for the reporting id; append when it is not held.
            S_RPT_RD:
            begin
                if (idx_reg == cnt_reg)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = cnt_reg[AW-1:0];
                    cnt_next   = cnt_reg + CNT_W'(1);
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_RPT_CMP;
                end
            end

            S_RPT_CMP:
            begin
                if (rd_entry.id == id_reg)
                begin
                    ram_we     = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = S_RPT_RD;
                end
            end

            // Removal pass: drop entries behind the current sequence.
            S_PR_RD:
            begin
                if (idx_reg >= cnt_reg)
                begin
                    idx_next   = '0;
                    state_next = S_CK_RD;
                end
                else
                begin
                    state_next = S_PR_CMP;
                end
            end

            S_PR_CMP:
            begin
                if (rd_entry.seq < cur_reg)
                begin
                    if (cnt_reg > CNT_W'(1))
                    begin
                        ram_raddr  = AW'(cnt_reg - CNT_W'(1));
                        state_next = S_PR_MOVE;
                    end
                    else
                    begin
                        cnt_next   = '0;
                        cur_next   = '0;
                        rep_next   = '0;
                        idx_next   = idx_reg + CNT_W'(1);
                        state_next = S_PR_RD;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = S_PR_RD;
                end
            end

            // The last entry takes the removed slot and is not checked again.
            S_PR_MOVE:
            begin
                ram_we     = 1'b1;
                ram_wdata  = rd_entry;
                cnt_next   = cnt_reg - CNT_W'(1);
                idx_next   = idx_reg + CNT_W'(1);
                state_next = S_PR_RD;
            end

            // Acknowledgement pass: every entry must be ahead of the sequence.
            S_CK_RD:
            begin
                if (idx_reg >= cnt_reg)
                begin
                    ack_next   = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_CK_CMP;
                end
            end

            S_CK_CMP:
            begin
                if (rd_entry.seq <= cur_reg)
                begin
                    ack_next   = 1'b0;
                    state_next = S_FIN;
                end
                else
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = S_CK_RD;
                end
            end

            // Finish the tick once the output register is free.
            S_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (kind_reg == KIND_NONE)
                    begin
                        out_sv_next   = 1'b0;
                        out_kind_next = kind_reg;
                        out_seq_next  = cur_reg;
                        out_cnt_next  = cnt_reg;
                    end
                    else if (!run_reg)
                    begin
                        kind_next     = KIND_NONE;
                        cur_next      = '0;
                        rep_next      = '0;
                        out_sv_next   = 1'b0;
                        out_kind_next = KIND_NONE;
                        out_seq_next  = '0;
                        out_cnt_next  = cnt_reg;
                    end
                    else
                    begin
                        out_sv_next   = 1'b1;
                        out_kind_next = kind_reg;
                        out_seq_next  = cur1;
                        out_cnt_next  = cnt_reg;
                        if (rep2 > REP_W'(maxrep_reg))
                        begin
                            rep_next = '0;
                            cur_next = cur1 + SEQ_W'(1);
                        end
                        else
                        begin
                            rep_next = rep2;
                            cur_next = cur1;
                        end
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            kind_reg      <= KIND_NONE;
            cur_reg       <= '0;
            rep_reg       <= '0;
            maxrep_reg    <= MAX_REPEATS_RST;
            test_reg      <= 1'b0;
            run_reg       <= 1'b0;
            ack_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_sv_reg    <= 1'b0;
            out_kind_reg  <= KIND_NONE;
            out_seq_reg   <= '0;
            out_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            idx_reg       <= idx_next;
            kind_reg      <= kind_next;
            cur_reg       <= cur_next;
            rep_reg       <= rep_next;
            maxrep_reg    <= maxrep_next;
            test_reg      <= test_next;
            run_reg       <= run_next;
            ack_reg       <= ack_next;
            out_valid_reg <= out_valid_next;
            out_sv_reg    <= out_sv_next;
            out_kind_reg  <= out_kind_next;
            out_seq_reg   <= out_seq_next;
            out_cnt_reg   <= out_cnt_next;
        end
    end

    // Report payload capture on each input transfer.
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            id_reg  <= s_tdata[15:0];
            seq_reg <= s_tdata[31:16];
        end
    end

    // The table never holds more entries than its depth.
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(TABLE_DEPTH))
        else $error("entry count exceeds table depth");

    // A sent packet always carries an active update kind.
    a_sent_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_sv_reg) |-> (out_kind_reg != KIND_NONE))
        else $error("send result without an update kind");

    // Moving the last entry only happens with at least two entries held.
    a_move_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PR_MOVE) |-> (cnt_reg > CNT_W'(1)))
        else $error("entry move with fewer than two entries");

    // Table writes stay within the held entries or append right after them.
    a_write_addr: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (CNT_W'(ram_waddr) <= cnt_reg))
        else $error("table write beyond the held entries");

    // A tick in progress finishes only after its passes ran to an end.
    a_fin_entry: assert property (@(posedge clk) disable iff (!rst_n)
        ($past(state_reg) != S_FIN && state_reg == S_FIN && run_reg) |->
            ($past(state_reg) == S_CK_RD || $past(state_reg) == S_CK_CMP))
        else $error("tick finished without the acknowledgement pass");

endmodule

`default_nettype wire
